/* rtl/core/sqmm_pkg.sv */
// ----------------------------------------------------------------------------
// sqmm_pkg: shared types and constants for the square matrix multiply/add block
// Operation and register codes, sequencer states, and the control structs
// passed between the sequencer, the MAC unit and the top level.
// ----------------------------------------------------------------------------
package sqmm_pkg;

	localparam int DATA_W      = 32;
	localparam int IDX_W       = 3;
	localparam int SIZE_W      = 4;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 4;
	localparam int MAX_DIM_DEF = 8;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd2;

	typedef enum logic {
		OP_MULTIPLY = 1'b0,
		OP_ADD      = 1'b1
	} op_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OPERATION_MODE = 1'b0,
		REG_MATRIX_SIZE    = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMIT
	} seq_state_t;

	// One operand fetch issued to the MAC pipeline
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} issue_t;

	// Load strobe for the result register
	typedef struct packed {
		logic             load;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             last;
	} emit_t;

endpackage

/* rtl/core/sqmm_ram.sv */
// ----------------------------------------------------------------------------
// sqmm_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sqmm_ram #(
	parameter int  WIDTH = 32,
	parameter int  DEPTH = 64,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* rtl/core/sqmm_mac.sv */
// ----------------------------------------------------------------------------
// sqmm_mac: shared multiply/add-accumulate unit
// Takes operand pairs from the two stores in the cycle after issue, forms the
// product (or sum in add mode), registers it, then accumulates. Pulses done
// once the last term of a dot product is in the accumulator.
// ----------------------------------------------------------------------------
module sqmm_mac (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sqmm_pkg::op_mode_t           mode,
	input  sqmm_pkg::issue_t             issue,
	input  logic [sqmm_pkg::DATA_W-1:0]  a_data,
	input  logic [sqmm_pkg::DATA_W-1:0]  b_data,
	output logic [sqmm_pkg::DATA_W-1:0]  acc,
	output logic                         done
);
	import sqmm_pkg::*;

	issue_t              tag_s1;
	issue_t              tag_s2;
	logic [DATA_W-1:0]   prod_s2;
	logic [DATA_W-1:0]   acc_q;
	logic                done_q;

	// tags are registered alongside the RAM read, so tag_s1 lines up with the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			tag_s1 <= issue;
			tag_s2 <= tag_s1;
			done_q <= tag_s2.valid && tag_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s1.valid) begin
			if (mode == OP_ADD) begin
				prod_s2 <= a_data + b_data;
			end else begin
				prod_s2 <= a_data * b_data;  // low 32 bits only
			end
		end
		if (tag_s2.valid) begin
			acc_q <= tag_s2.first ? prod_s2 : acc_q + prod_s2;
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

/* rtl/core/sqmm_ctrl.sv */
// ----------------------------------------------------------------------------
// sqmm_ctrl: result sequencer
// Walks rows, columns and the inner index, issues operand fetches to the
// stores and the MAC, and hands each finished element to the result register.
// ----------------------------------------------------------------------------
module sqmm_ctrl #(
	parameter int  MAX_DIM = sqmm_pkg::MAX_DIM_DEF,
	localparam int DEPTH   = MAX_DIM * MAX_DIM,
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  sqmm_pkg::op_mode_t            cfg_mode,
	input  logic [sqmm_pkg::SIZE_W-1:0]   cfg_size,
	input  logic                          slot_free,
	input  logic                          mac_done,
	output sqmm_pkg::op_mode_t            mode,
	output sqmm_pkg::issue_t              issue,
	output logic [ADDR_W-1:0]             rd_addr_a,
	output logic [ADDR_W-1:0]             rd_addr_b,
	output sqmm_pkg::emit_t               emit,
	output logic                          busy
);
	import sqmm_pkg::*;

	localparam int LIN_W = IDX_W + SIZE_W;

	seq_state_t        state_q, state_d;
	logic [IDX_W-1:0]  r_q, r_d;
	logic [IDX_W-1:0]  c_q, c_d;
	logic [IDX_W-1:0]  k_q, k_d;
	logic [IDX_W-1:0]  nm1_q;
	logic [IDX_W-1:0]  nm1_eff;
	op_mode_t          mode_q;
	logic [IDX_W-1:0]  last_k;
	logic [IDX_W-1:0]  a_col;
	logic [IDX_W-1:0]  b_row;

	function automatic logic [ADDR_W-1:0] lin(input logic [IDX_W-1:0] row,
	                                         input logic [IDX_W-1:0] col);
		logic [LIN_W-1:0] v;
		v = LIN_W'(row) * LIN_W'(MAX_DIM) + LIN_W'(col);
		return v[ADDR_W-1:0];
	endfunction

	// size 0 runs as 1, sizes above MAX_DIM run as MAX_DIM
	always_comb begin
		priority if (cfg_size == '0) begin
			nm1_eff = '0;
		end else if (cfg_size > SIZE_W'(MAX_DIM)) begin
			nm1_eff = IDX_W'(MAX_DIM - 1);
		end else begin
			nm1_eff = IDX_W'(cfg_size - 1'b1);
		end
	end

	assign last_k    = (mode_q == OP_ADD) ? '0 : nm1_q;
	assign a_col     = (mode_q == OP_ADD) ? c_q : k_q;
	assign b_row     = (mode_q == OP_ADD) ? r_q : k_q;
	assign rd_addr_a = lin(r_q, a_col);
	assign rd_addr_b = lin(b_row, c_q);
	assign mode      = mode_q;
	assign busy      = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			r_q     <= r_d;
			c_q     <= c_d;
			k_q     <= k_d;
		end
	end

	// run settings captured at start; the user keeps config quiet while busy, the block does not enforce it
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			nm1_q  <= nm1_eff;
			mode_q <= cfg_mode;
		end
	end

	always_comb begin
		state_d    = state_q;
		r_d        = r_q;
		c_d        = c_q;
		k_d        = k_q;
		issue      = '0;
		emit.load  = 1'b0;
		emit.row   = r_q;
		emit.col   = c_q;
		emit.last  = (r_q == nm1_q) && (c_q == nm1_q);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_ISSUE;
					r_d     = '0;
					c_d     = '0;
					k_d     = '0;
				end
			end
			ST_ISSUE: begin
				issue.valid = 1'b1;
				issue.first = (k_q == '0);
				issue.last  = (k_q == last_k);
				if (k_q == last_k) begin
					state_d = ST_DRAIN;
					k_d     = '0;
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (mac_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					emit.load = 1'b1;
					if (emit.last) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_ISSUE;
						if (c_q == nm1_q) begin
							c_d = '0;
							r_d = r_q + 1'b1;
						end else begin
							c_d = c_q + 1'b1;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// the accumulator only finishes while we are waiting for it
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == ST_DRAIN)
		else $error("MAC finished outside drain");

	// a new dot product never starts in the middle of an issue burst
	a_first_after_gap: assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid && issue.first |-> $past(state_q) != ST_ISSUE)
		else $error("first term issued back to back with a previous burst");

endmodule

/* rtl/core/square_matrix_multiply_add.sv */
// ----------------------------------------------------------------------------
// square_matrix_multiply_add: integer square matrix multiply / add engine
// Loads A and B one element per transaction, then streams n*n results.
//
// Input channel (in_valid/in_stall): each transaction writes one element of
// A or B at (row, column); loads stream back to back while in_stall is low.
// A transaction with start_compute set is stored, then the block goes busy
// (in_stall high) and produces all n*n results in row-major order.
// Output channel (out_valid/out_stall): one transaction per result element,
// last_of_run set on element (n-1, n-1).
// One shared MAC is fed from two registered-read RAMs. Each result takes
// n operand fetches in multiply mode, or a single fetch in add mode, then
// the MAC pipeline fills and the result is handed off to the output
// register before the fetches for the next result begin.
// Receiver stall: a result waits in the output register; the sequencer
// holds the next finished element until that register is free. Loads are
// accepted again once the last result is in the output register.
// Reset: operation_mode = multiply, matrix_size = 2, output empty. Store
// contents are undefined until written.
// ----------------------------------------------------------------------------
module square_matrix_multiply_add #(
	parameter int MAX_DIM = sqmm_pkg::MAX_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_write,
	input  logic [sqmm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sqmm_pkg::CFG_DATA_W-1:0]   cfg_data,
	// element load channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              matrix_select,
	input  logic [sqmm_pkg::IDX_W-1:0]        row_index,
	input  logic [sqmm_pkg::IDX_W-1:0]        column_index,
	input  logic signed [sqmm_pkg::DATA_W-1:0] element_value,
	input  logic                              start_compute,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [sqmm_pkg::IDX_W-1:0]        result_row,
	output logic [sqmm_pkg::IDX_W-1:0]        result_column,
	output logic signed [sqmm_pkg::DATA_W-1:0] result_value,
	output logic                              last_of_run
);
	import sqmm_pkg::*;

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LIN_W  = IDX_W + SIZE_W;

	// configuration registers
	op_mode_t            mode_cfg_q;
	logic [SIZE_W-1:0]   size_cfg_q;

	// load path
	logic                in_xact;
	logic                in_range;
	logic [LIN_W-1:0]    wr_lin;
	logic [ADDR_W-1:0]   wr_addr;
	logic                wr_a;
	logic                wr_b;

	// compute path
	logic [ADDR_W-1:0]   rd_addr_a;
	logic [ADDR_W-1:0]   rd_addr_b;
	logic [DATA_W-1:0]   a_data;
	logic [DATA_W-1:0]   b_data;
	logic [DATA_W-1:0]   acc;
	logic                mac_done;
	op_mode_t            run_mode;
	issue_t              issue;
	emit_t               emit;
	logic                busy;
	logic                slot_free;

	// output register
	logic                out_valid_q;
	logic [IDX_W-1:0]    result_row_q;
	logic [IDX_W-1:0]    result_column_q;
	logic [DATA_W-1:0]   result_value_q;
	logic                last_of_run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_cfg_q <= OP_MULTIPLY;
			size_cfg_q <= SIZE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_OPERATION_MODE: mode_cfg_q <= op_mode_t'(cfg_data[0]);
				REG_MATRIX_SIZE:    size_cfg_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// loads outside the store are dropped; start still counts
	assign in_stall = busy;
	assign in_xact  = in_valid && !in_stall;
	assign in_range = (SIZE_W'(row_index) < SIZE_W'(MAX_DIM))
	               && (SIZE_W'(column_index) < SIZE_W'(MAX_DIM));
	assign wr_lin   = LIN_W'(row_index) * LIN_W'(MAX_DIM) + LIN_W'(column_index);
	assign wr_addr  = wr_lin[ADDR_W-1:0];
	assign wr_a     = in_xact && in_range && !matrix_select;
	assign wr_b     = in_xact && in_range && matrix_select;

	sqmm_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store_a (
		.clk     (clk),
		.wr_en   (wr_a),
		.wr_addr (wr_addr),
		.wr_data (element_value),
		.rd_addr (rd_addr_a),
		.rd_data (a_data)
	);

	sqmm_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store_b (
		.clk     (clk),
		.wr_en   (wr_b),
		.wr_addr (wr_addr),
		.wr_data (element_value),
		.rd_addr (rd_addr_b),
		.rd_data (b_data)
	);

	sqmm_ctrl #(
		.MAX_DIM (MAX_DIM)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_xact && start_compute),
		.cfg_mode  (mode_cfg_q),
		.cfg_size  (size_cfg_q),
		.slot_free (slot_free),
		.mac_done  (mac_done),
		.mode      (run_mode),
		.issue     (issue),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.emit      (emit),
		.busy      (busy)
	);

	sqmm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.mode   (run_mode),
		.issue  (issue),
		.a_data (a_data),
		.b_data (b_data),
		.acc    (acc),
		.done   (mac_done)
	);

	// result register: free when empty or being taken this cycle
	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			result_row_q    <= emit.row;
			result_column_q <= emit.col;
			result_value_q  <= acc;
			last_of_run_q   <= emit.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_row    = result_row_q;
	assign result_column = result_column_q;
	assign result_value  = result_value_q;
	assign last_of_run   = last_of_run_q;

	// a held result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !emit.load)
		else $error("result register overwritten while stalled");

	// a start transaction always takes the block busy
	a_start_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && start_compute |=> in_stall)
		else $error("start transaction did not begin a run");

endmodule

/* tb/square_matrix_multiply_add_tb.sv */
// ----------------------------------------------------------------------------
// square_matrix_multiply_add_tb: self-checking bench for the matrix engine
// Loads A and B elements over the input channel and keeps its own copy of
// both operand stores and the two registers. On every start transaction it
// predicts all n*n results and checks each output transaction against them
// in order. Directed cases come first, then randomized jobs under three
// sender/receiver idling profiles.
// ----------------------------------------------------------------------------
module square_matrix_multiply_add_tb;
	import sqmm_pkg::*;

	localparam int DIM           = MAX_DIM_DEF;
	localparam int STORE_DEPTH   = DIM * DIM;
	localparam int STALL_LIMIT   = 4000;	// cycles with no transaction on any channel
	localparam int SETTLE_CYCLES = 24;		// idle margin after the last predicted result is taken

	// operand select codes on matrix_select
	localparam logic SEL_A = 1'b0;
	localparam logic SEL_B = 1'b1;

	typedef struct {
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [DATA_W-1:0] value;
		logic              last;
	} result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_write;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic                     matrix_select;
	logic [IDX_W-1:0]         row_index;
	logic [IDX_W-1:0]         column_index;
	logic signed [DATA_W-1:0] element_value;
	logic                     start_compute;
	logic                     out_valid;
	logic                     out_stall;
	logic [IDX_W-1:0]         result_row;
	logic [IDX_W-1:0]         result_column;
	logic signed [DATA_W-1:0] result_value;
	logic                     last_of_run;

	// shadow of the block's state
	logic [DATA_W-1:0] a_store [STORE_DEPTH];
	logic [DATA_W-1:0] b_store [STORE_DEPTH];
	bit                a_written [STORE_DEPTH];
	bit                b_written [STORE_DEPTH];
	op_mode_t          mode_reg;
	logic [SIZE_W-1:0] size_reg;

	result_t pending_results [$];
	int      error_count  = 0;
	int      items_sent   = 0;
	int      quiet_cycles = 0;
	int      tx_idle_pct  = 0;
	int      rx_idle_pct  = 0;

	square_matrix_multiply_add uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.matrix_select (matrix_select),
		.row_index     (row_index),
		.column_index  (column_index),
		.element_value (element_value),
		.start_compute (start_compute),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_row    (result_row),
		.result_column (result_column),
		.result_value  (result_value),
		.last_of_run   (last_of_run)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver back-pressure, independent of out_valid
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// Watchdog: a correct run never goes this long without a transaction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Result checker: every output transaction against the oldest prediction
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: row %0d col %0d value %h last %b",
					result_row, result_column, result_value, last_of_run);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (result_row !== want.row) begin
					$error("result_row mismatch: expected %0d, got %0d", want.row, result_row);
					error_count++;
				end
				if (result_column !== want.col) begin
					$error("result_column mismatch: expected %0d, got %0d",
						want.col, result_column);
					error_count++;
				end
				if (result_value !== want.value) begin
					$error("result_value mismatch: expected %h, got %h",
						want.value, result_value);
					error_count++;
				end
				if (last_of_run !== want.last) begin
					$error("last_of_run mismatch: expected %b, got %b", want.last, last_of_run);
					error_count++;
				end
			end
		end
	end

	// n as the block uses it: 0 reads as 1, anything above DIM as DIM
	function automatic int effective_size();
		if (size_reg == 0)
			return 1;
		if (size_reg > DIM)
			return DIM;
		return int'(size_reg);
	endfunction

	// Queue the n*n results of one compute, row-major
	function automatic void predict_matrix_results();
		int                n;
		logic [DATA_W-1:0] acc;
		result_t           res;
		n = effective_size();
		for (int r = 0; r < n; r++) begin
			for (int c = 0; c < n; c++) begin
				if (mode_reg == OP_ADD)
					acc = a_store[r*DIM + c] + b_store[r*DIM + c];
				else begin
					acc = '0;
					for (int k = 0; k < n; k++)
						acc += a_store[r*DIM + k] * b_store[k*DIM + c];	// low 32 bits only
				end
				res.row   = IDX_W'(r);
				res.col   = IDX_W'(c);
				res.value = acc;
				res.last  = (r == n - 1) && (c == n - 1);
				pending_results.push_back(res);
			end
		end
	endfunction

	// Bias toward corner values so wrap-around gets exercised
	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0001;
			4: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Mostly small sizes; the clamp cases now and then
	function automatic logic [CFG_DATA_W-1:0] pick_size();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return '0;
		if (roll < 20)
			return CFG_DATA_W'($urandom_range(15, DIM + 1));
		if (roll < 35)
			return CFG_DATA_W'($urandom_range(DIM, 4));
		return CFG_DATA_W'($urandom_range(3, 1));
	endfunction

	task automatic set_idling(input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
	endtask

	// Drop valid and wait until every predicted result has been taken
	task automatic wait_until_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Registers only change with the block idle
	task automatic write_register(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] data);
		wait_until_drained();
		cfg_write <= 1'b1;
		cfg_index <= which;
		cfg_data  <= data;
		@(posedge clk);
		case (which)
			REG_OPERATION_MODE: mode_reg = op_mode_t'(data[0]);
			REG_MATRIX_SIZE:    size_reg = data;
			default: ;
		endcase
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// One load transaction; valid is left high so back-to-back items stream
	task automatic send_element(input logic sel, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] value, input logic go);
		int idx;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		matrix_select <= sel;
		row_index     <= row;
		column_index  <= col;
		element_value <= value;
		start_compute <= go;
		do
			@(posedge clk);
		while (in_stall);
		idx = row*DIM + col;
		if (sel == SEL_A) begin
			a_store[idx]   = value;
			a_written[idx] = 1'b1;
		end else begin
			b_store[idx]   = value;
			b_written[idx] = 1'b1;
		end
		items_sent++;
		if (go)
			predict_matrix_results();
	endtask

	// Location code: operand * DIM*DIM + row * DIM + col
	task automatic send_coded(input int code, input logic go);
		send_element(logic'(code / STORE_DEPTH), IDX_W'((code % STORE_DEPTH) / DIM),
			IDX_W'(code % DIM), pick_value(), go);
	endtask

	// Well-formed job: every element inside n is written before the start
	// transaction, mixed with a few stray loads anywhere in the stores.
	task automatic load_and_compute(input bit full_reload);
		int n;
		int idx;
		int pick;
		int tmp;
		int loads [$];
		n = effective_size();
		for (int r = 0; r < n; r++) begin
			for (int c = 0; c < n; c++) begin
				idx = r*DIM + c;
				if (full_reload || !a_written[idx])
					loads.push_back(idx);
				if (full_reload || !b_written[idx])
					loads.push_back(STORE_DEPTH + idx);
			end
		end
		repeat ($urandom_range(4))
			loads.push_back($urandom_range(2*STORE_DEPTH - 1));
		for (int i = loads.size() - 1; i > 0; i--) begin
			pick       = $urandom_range(i);
			tmp        = loads[i];
			loads[i]   = loads[pick];
			loads[pick] = tmp;
		end
		foreach (loads[i])
			send_coded(loads[i], 1'b0);
		// now and then hold the start back until the previous run is out
		if ($urandom_range(4) == 0)
			wait_until_drained();
		send_coded($urandom_range(2*STORE_DEPTH - 1), 1'b1);
	endtask

	// Reset values: multiply, n = 2, corner operands
	task automatic test_reset_defaults();
		send_element(SEL_A, 0, 0, 32'h7FFF_FFFF, 1'b0);
		send_element(SEL_A, 0, 1, 32'h8000_0000, 1'b0);
		send_element(SEL_A, 1, 0, 32'hFFFF_FFFF, 1'b0);
		send_element(SEL_A, 1, 1, 32'h0000_0001, 1'b0);
		send_element(SEL_B, 0, 0, 32'hFFFF_FFFF, 1'b0);
		send_element(SEL_B, 0, 1, 32'h7FFF_FFFF, 1'b0);
		send_element(SEL_B, 1, 0, 32'h8000_0000, 1'b0);
		send_element(SEL_B, 1, 1, 32'h0000_0002, 1'b1);
	endtask

	// Add mode: sums wrap; stores kept from the last test but for the start item, which also loads
	task automatic test_add_wrap();
		write_register(REG_OPERATION_MODE, {3'b000, OP_ADD});
		send_element(SEL_B, 1, 1, 32'hFFFF_FFFF, 1'b1);
	endtask

	// Size 0 clamps to 1; loads outside n stored but unused; upper
	// cfg bits ignored by the mode register
	task automatic test_size_clamp_low();
		write_register(REG_MATRIX_SIZE, 4'd0);
		write_register(REG_OPERATION_MODE, {3'b111, OP_MULTIPLY});
		send_element(SEL_B, 0, 0, 32'h8000_0000, 1'b1);
		write_register(REG_MATRIX_SIZE, 4'd1);
		send_element(SEL_A, 7, 7, 32'h7FFF_FFFF, 1'b0);
		send_element(SEL_B, 7, 0, 32'h8000_0000, 1'b0);
		send_element(SEL_A, 3, 5, 32'hFFFF_FFFF, 1'b0);
		send_element(SEL_A, 0, 0, 32'hFFFF_FFFF, 1'b1);
		// start riding on a load outside n
		send_element(SEL_B, 6, 2, 32'h1234_5678, 1'b1);
	endtask

	// Size 15 clamps to 8: fill both stores completely, then n = 8 exact
	task automatic test_full_size();
		write_register(REG_MATRIX_SIZE, 4'd15);
		write_register(REG_OPERATION_MODE, {3'b000, OP_MULTIPLY});
		load_and_compute(1'b0);
		write_register(REG_MATRIX_SIZE, 4'd8);
		write_register(REG_OPERATION_MODE, {3'b010, OP_ADD});
		load_and_compute(1'b0);
	endtask

	// Random jobs until the item count reaches the target
	task automatic test_random_jobs(input int target);
		int n;
		while (items_sent < target) begin
			if ($urandom_range(99) < 35) begin
				write_register(REG_OPERATION_MODE, CFG_DATA_W'($urandom_range(15)));
				write_register(REG_MATRIX_SIZE, pick_size());
			end
			n = effective_size();
			load_and_compute(n <= 3 && $urandom_range(3) == 0);
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_write     <= 1'b0;
		cfg_index     <= REG_OPERATION_MODE;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		matrix_select <= SEL_A;
		row_index     <= '0;
		column_index  <= '0;
		element_value <= '0;
		start_compute <= 1'b0;
		mode_reg = OP_MULTIPLY;
		size_reg = SIZE_RESET;
		foreach (a_written[i]) begin
			a_written[i] = 1'b0;
			b_written[i] = 1'b0;
			a_store[i]   = '0;
			b_store[i]   = '0;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idle 30%, receiver 55%
		set_idling(30, 55);
		test_reset_defaults();
		test_add_wrap();
		test_size_clamp_low();
		test_full_size();
		test_random_jobs(items_sent + 20);

		// sender idle 55%, receiver 30%
		set_idling(55, 30);
		test_random_jobs(items_sent + 25);

		// full rate both ways
		set_idling(0, 0);
		test_random_jobs(items_sent + 25);

		wait_until_drained();
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* files.f */
rtl/core/sqmm_pkg.sv
rtl/core/sqmm_ram.sv
rtl/core/sqmm_mac.sv
rtl/core/sqmm_ctrl.sv
rtl/core/square_matrix_multiply_add.sv
tb/square_matrix_multiply_add_tb.sv
